### src/i2cm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2cm_pkg
// Shared types and constants of the I2C master bit engine: request and
// result structs, command codes, phase encoding and timing constants.
// ----------------------------------------------------------------------------
package i2cm_pkg;

	localparam logic [2:0] FN_START = 3'd0;
	localparam logic [2:0] FN_STOP  = 3'd1;
	localparam logic [2:0] FN_SEND  = 3'd2;
	localparam logic [2:0] FN_ACK   = 3'd3;
	localparam logic [2:0] FN_READ  = 3'd4;

	localparam logic [7:0] TPU_RESET = 8'd72;
	localparam logic [3:0] BYTE_BITS = 4'd8;
	localparam int unsigned WAIT_W = 10;

	typedef struct packed {
		logic       cmd_valid;
		logic [2:0] func;
		logic [7:0] tx_byte;
		logic       send_ack;
		logic       sda_in;
	} req_t;

	typedef struct packed {
		logic       scl_level;
		logic       sda_level;
		logic       sda_drive;
		logic       busy_res;
		logic       done_res;
		logic [7:0] rx_byte;
		logic       ack_seen;
	} rsp_t;

	typedef enum logic [15:0] {
		PH_IDLE    = 16'h0001,
		PH_ST_HI   = 16'h0002,
		PH_ST_LO   = 16'h0004,
		PH_SP_SDA  = 16'h0008,
		PH_SP_CLK  = 16'h0010,
		PH_SP_REL  = 16'h0020,
		PH_TX_SET  = 16'h0040,
		PH_TX_HIGH = 16'h0080,
		PH_TX_LOW  = 16'h0100,
		PH_AK_REL  = 16'h0200,
		PH_AK_HIGH = 16'h0400,
		PH_RX_LOW  = 16'h0800,
		PH_RX_HIGH = 16'h1000,
		PH_RA_SET  = 16'h2000,
		PH_RA_HIGH = 16'h4000,
		PH_RA_TAIL = 16'h8000
	} phase_t;

	typedef enum logic [1:0] {
		US_0 = 2'd0,
		US_2 = 2'd1,
		US_4 = 2'd2
	} us_t;

endpackage

### src/i2cm_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2cm_core
// Bus sequencer state and next-state logic. On each step it consumes one
// registered request, updates phase, counters and pins, and presents the
// result for that tick.
// ----------------------------------------------------------------------------
module i2cm_core (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            step,
	input  i2cm_pkg::req_t  req,
	input  logic [7:0]      tpu,
	output i2cm_pkg::rsp_t  rsp
);

	i2cm_pkg::phase_t             phase_q, phase_n, tgt;
	logic [3:0]                   bit_q, bit_n, bit_inc;
	logic [7:0]                   shift_q, shift_n;
	logic [i2cm_pkg::WAIT_W-1:0]  wait_q, wait_n, wait_dec;
	logic                         ackc_q, ackc_n;
	logic                         scl_q, scl_n, sda_q, sda_n, drv_q, drv_n;
	logic [7:0]                   rx_q, rx_n;
	logic                         ack_q, ack_n;
	logic                         fin, do_enter;
	i2cm_pkg::us_t                us;
	logic [7:0]                   tick_base;

	assign tick_base = (tpu == 8'd0) ? 8'd1 : tpu;
	assign bit_inc   = bit_q + 4'd1;
	assign wait_dec  = (wait_q != '0) ? wait_q - 1'b1 : '0;

	always_comb begin
		phase_n  = phase_q;
		bit_n    = bit_q;
		shift_n  = shift_q;
		wait_n   = wait_q;
		ackc_n   = ackc_q;
		scl_n    = scl_q;
		sda_n    = sda_q;
		drv_n    = drv_q;
		rx_n     = rx_q;
		ack_n    = ack_q;
		fin      = 1'b0;
		do_enter = 1'b0;
		tgt      = i2cm_pkg::PH_IDLE;
		us       = i2cm_pkg::US_2;

		if (phase_q == i2cm_pkg::PH_IDLE) begin
			if (req.cmd_valid && (req.func inside {[i2cm_pkg::FN_START:i2cm_pkg::FN_READ]})) begin
				bit_n    = 4'd0;
				do_enter = 1'b1;
				case (req.func)
					i2cm_pkg::FN_START: tgt = i2cm_pkg::PH_ST_HI;
					i2cm_pkg::FN_STOP:  tgt = i2cm_pkg::PH_SP_SDA;
					i2cm_pkg::FN_SEND: begin
						shift_n = req.tx_byte;
						tgt     = i2cm_pkg::PH_TX_SET;
					end
					i2cm_pkg::FN_ACK:   tgt = i2cm_pkg::PH_AK_REL;
					default: begin
						ackc_n  = req.send_ack;
						shift_n = 8'd0;
						tgt     = i2cm_pkg::PH_RX_LOW;
					end
				endcase
			end
		end else begin
			wait_n = wait_dec;
			if (wait_dec == '0) begin
				case (phase_q)
					i2cm_pkg::PH_ST_HI: begin
						do_enter = 1'b1;
						tgt      = i2cm_pkg::PH_ST_LO;
					end
					i2cm_pkg::PH_ST_LO: begin
						scl_n = 1'b0;
						fin   = 1'b1;
					end
					i2cm_pkg::PH_SP_SDA: begin
						do_enter = 1'b1;
						tgt      = i2cm_pkg::PH_SP_CLK;
					end
					i2cm_pkg::PH_SP_CLK: begin
						do_enter = 1'b1;
						tgt      = i2cm_pkg::PH_SP_REL;
					end
					i2cm_pkg::PH_TX_SET: begin
						do_enter = 1'b1;
						tgt      = i2cm_pkg::PH_TX_HIGH;
					end
					i2cm_pkg::PH_TX_HIGH: begin
						do_enter = 1'b1;
						tgt      = i2cm_pkg::PH_TX_LOW;
					end
					i2cm_pkg::PH_TX_LOW: begin
						bit_n = bit_inc;
						if (bit_inc < i2cm_pkg::BYTE_BITS) begin
							shift_n  = {shift_q[6:0], 1'b0};
							do_enter = 1'b1;
							tgt      = i2cm_pkg::PH_TX_SET;
						end else begin
							fin = 1'b1;
						end
					end
					i2cm_pkg::PH_AK_REL: begin
						do_enter = 1'b1;
						tgt      = i2cm_pkg::PH_AK_HIGH;
					end
					i2cm_pkg::PH_AK_HIGH: begin
						ack_n = req.sda_in;
						scl_n = 1'b0;
						fin   = 1'b1;
					end
					i2cm_pkg::PH_RX_LOW: begin
						do_enter = 1'b1;
						tgt      = i2cm_pkg::PH_RX_HIGH;
					end
					i2cm_pkg::PH_RX_HIGH: begin
						shift_n  = {shift_q[6:0], req.sda_in};
						bit_n    = bit_inc;
						do_enter = 1'b1;
						tgt      = (bit_inc < i2cm_pkg::BYTE_BITS) ? i2cm_pkg::PH_RX_LOW
						                                           : i2cm_pkg::PH_RA_SET;
					end
					i2cm_pkg::PH_RA_SET: begin
						do_enter = 1'b1;
						tgt      = i2cm_pkg::PH_RA_HIGH;
					end
					i2cm_pkg::PH_RA_HIGH: begin
						scl_n = 1'b0;
						if (ackc_q) begin
							rx_n = shift_q;
							fin  = 1'b1;
						end else begin
							do_enter = 1'b1;
							tgt      = i2cm_pkg::PH_RA_TAIL;
						end
					end
					i2cm_pkg::PH_RA_TAIL: begin
						rx_n = shift_q;
						fin  = 1'b1;
					end
					default: fin = 1'b1;
				endcase
			end
		end

		if (fin) begin
			phase_n = i2cm_pkg::PH_IDLE;
			wait_n  = '0;
		end

		if (do_enter) begin
			phase_n = tgt;
			case (tgt)
				i2cm_pkg::PH_ST_HI: begin
					drv_n = 1'b1;
					sda_n = 1'b1;
					scl_n = 1'b1;
					us    = i2cm_pkg::US_4;
				end
				i2cm_pkg::PH_ST_LO: begin
					sda_n = 1'b0;
					us    = i2cm_pkg::US_4;
				end
				i2cm_pkg::PH_SP_SDA: begin
					drv_n = 1'b1;
					sda_n = 1'b0;
					us    = i2cm_pkg::US_0;
				end
				i2cm_pkg::PH_SP_CLK: begin
					scl_n = 1'b1;
					us    = i2cm_pkg::US_4;
				end
				i2cm_pkg::PH_SP_REL: begin
					sda_n = 1'b1;
					us    = i2cm_pkg::US_4;
				end
				i2cm_pkg::PH_TX_SET: begin
					drv_n = 1'b1;
					scl_n = 1'b0;
					sda_n = shift_n[7];
				end
				i2cm_pkg::PH_TX_HIGH: scl_n = 1'b1;
				i2cm_pkg::PH_TX_LOW:  scl_n = 1'b0;
				i2cm_pkg::PH_AK_REL: begin
					drv_n = 1'b0;
					sda_n = 1'b1;
				end
				i2cm_pkg::PH_AK_HIGH: scl_n = 1'b1;
				i2cm_pkg::PH_RX_LOW: begin
					drv_n = 1'b0;
					sda_n = 1'b1;
					scl_n = 1'b0;
				end
				i2cm_pkg::PH_RX_HIGH: scl_n = 1'b1;
				i2cm_pkg::PH_RA_SET: begin
					scl_n = 1'b0;
					drv_n = 1'b1;
					sda_n = ~ackc_n;
				end
				i2cm_pkg::PH_RA_HIGH: scl_n = 1'b1;
				i2cm_pkg::PH_RA_TAIL: us = i2cm_pkg::US_2;
				default: begin
					phase_n = i2cm_pkg::PH_IDLE;
					us      = i2cm_pkg::US_0;
				end
			endcase
			case (us)
				i2cm_pkg::US_4: wait_n = {tick_base, 2'b00};
				i2cm_pkg::US_2: wait_n = {1'b0, tick_base, 1'b0};
				default:        wait_n = i2cm_pkg::WAIT_W'(1);
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= i2cm_pkg::PH_IDLE;
			bit_q   <= 4'd0;
			shift_q <= 8'd0;
			wait_q  <= '0;
			ackc_q  <= 1'b0;
			scl_q   <= 1'b1;
			sda_q   <= 1'b1;
			drv_q   <= 1'b1;
			rx_q    <= 8'd0;
			ack_q   <= 1'b0;
		end else if (step) begin
			phase_q <= phase_n;
			bit_q   <= bit_n;
			shift_q <= shift_n;
			wait_q  <= wait_n;
			ackc_q  <= ackc_n;
			scl_q   <= scl_n;
			sda_q   <= sda_n;
			drv_q   <= drv_n;
			rx_q    <= rx_n;
			ack_q   <= ack_n;
		end
	end

	always_comb begin
		rsp.scl_level = scl_n;
		rsp.sda_level = sda_n;
		rsp.sda_drive = drv_n;
		rsp.busy_res  = (phase_n != i2cm_pkg::PH_IDLE);
		rsp.done_res  = fin;
		rsp.rx_byte   = rx_n;
		rsp.ack_seen  = ack_n;
	end

endmodule

### src/i2c_master_bit_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2c_master_bit_engine
// I2C master pin sequencer: one request per bus tick, one result per request.
// ----------------------------------------------------------------------------
// path: a request passes through the request register, the sequencer step and the result register
// throughput: one request per cycle while rsp_stall does not hold a full result register; the
// sequencer step is combinational between the request register and the result register
// reset: bus idle, SCL and SDA high and driven, ticks_per_us 72, outputs empty
module i2c_master_bit_engine (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            req_valid,
	output logic            req_stall,
	input  i2cm_pkg::req_t  req,
	output logic            rsp_valid,
	input  logic            rsp_stall,
	output i2cm_pkg::rsp_t  rsp,
	input  logic            cfg_we,
	input  logic [7:0]      cfg_data
);

	logic            valid_s1;
	i2cm_pkg::req_t  req_s1;
	logic            step;
	logic            rsp_valid_q;
	i2cm_pkg::rsp_t  rsp_q;
	i2cm_pkg::rsp_t  core_rsp;
	logic [7:0]      tpu_q;

	assign step      = valid_s1 && (!rsp_valid_q || !rsp_stall);
	assign req_stall = valid_s1 && !step;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tpu_q <= i2cm_pkg::TPU_RESET;
		end else if (cfg_we) begin
			tpu_q <= cfg_data;
		end
	end

	// request register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!req_stall) begin
			valid_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && !req_stall) begin
			req_s1 <= req;
		end
	end

	i2cm_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.req    (req_s1),
		.tpu    (tpu_q),
		.rsp    (core_rsp)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (step) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_q <= '0;
		end else if (step) begin
			rsp_q <= core_rsp;
		end
	end

	a_done_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> !(rsp.done_res && rsp.busy_res))
		else $error("done and busy together");

	a_step_fills_out: assert property (@(posedge clk) disable iff (!arst_n)
		step |=> rsp_valid)
		else $error("stepped request produced no result");

	a_stall_needs_item: assert property (@(posedge clk) disable iff (!arst_n)
		req_stall |-> (valid_s1 && rsp_valid_q && rsp_stall))
		else $error("request stalled without back pressure");

	a_held_result: assert property (@(posedge clk) disable iff (!arst_n)
		!step |=> $stable(rsp_q))
		else $error("result changed without a step");

endmodule

### tb/sv/tb_i2c_master_bit_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_i2c_master_bit_engine
// Self-checking bench for the I2C master bit engine. Every request is one bus
// tick. A queue of ticks is filled per timing setting. Most ticks form whole
// start, stop, send, acknowledge and read sequences, with ignored commands
// and random SDA levels mixed in. A model of the pin sequencer predicts the
// pins, flags, received byte and acknowledge of every tick. The monitor
// compares each result against that prediction, field by field. Both sides
// idle and stall in random bursts, with one long receiver hold and one
// sender pause until everything has drained.
// ----------------------------------------------------------------------------
module tb_i2c_master_bit_engine;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	i2cm_pkg::req_t req = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	i2cm_pkg::rsp_t rsp;
	logic cfg_we = 1'b0;
	logic [7:0] cfg_data = 8'd0;

	always #2 clk = ~clk;

	i2c_master_bit_engine u_top (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp(rsp),
		.cfg_we(cfg_we),
		.cfg_data(cfg_data)
	);

	i2cm_pkg::req_t tick_q[$];
	i2cm_pkg::rsp_t pin_state_q[$];
	int pushed_cnt = 0;
	int taken_cnt = 0;
	int checked_cnt = 0;
	int err_cnt = 0;
	int work_items = 0;
	bit calm = 1'b0;

	// sequencer model
	logic [7:0] tick_rate = i2cm_pkg::TPU_RESET;
	i2cm_pkg::phase_t ph = i2cm_pkg::PH_IDLE;
	logic [3:0] bit_cnt = 4'd0;
	logic [7:0] shreg = 8'd0;
	int unsigned wait_left = 0;
	logic ack_sel = 1'b0;
	logic scl_q = 1'b1;
	logic sda_q = 1'b1;
	logic drv_q = 1'b1;
	logic [7:0] rx_q = 8'd0;
	logic ack_q = 1'b0;
	logic fin = 1'b0;

	function automatic int unsigned phase_len(input int unsigned us);
		int unsigned t;
		t = (tick_rate == 8'd0) ? 1 : tick_rate;
		t = t * us;
		return (t == 0) ? 1 : t;
	endfunction

	task automatic enter_phase(input i2cm_pkg::phase_t p);
		int unsigned us;
		us = 2;
		ph = p;
		case (p)
			i2cm_pkg::PH_ST_HI: begin
				drv_q = 1'b1; sda_q = 1'b1; scl_q = 1'b1; us = 4;
			end
			i2cm_pkg::PH_ST_LO: begin
				sda_q = 1'b0; us = 4;
			end
			i2cm_pkg::PH_SP_SDA: begin
				drv_q = 1'b1; sda_q = 1'b0; us = 0;
			end
			i2cm_pkg::PH_SP_CLK: begin
				scl_q = 1'b1; us = 4;
			end
			i2cm_pkg::PH_SP_REL: begin
				sda_q = 1'b1; us = 4;
			end
			i2cm_pkg::PH_TX_SET: begin
				drv_q = 1'b1; scl_q = 1'b0; sda_q = shreg[7];
			end
			i2cm_pkg::PH_TX_HIGH, i2cm_pkg::PH_AK_HIGH, i2cm_pkg::PH_RX_HIGH,
			i2cm_pkg::PH_RA_HIGH: scl_q = 1'b1;
			i2cm_pkg::PH_TX_LOW: scl_q = 1'b0;
			i2cm_pkg::PH_AK_REL: begin
				drv_q = 1'b0; sda_q = 1'b1;
			end
			i2cm_pkg::PH_RX_LOW: begin
				drv_q = 1'b0; sda_q = 1'b1; scl_q = 1'b0;
			end
			i2cm_pkg::PH_RA_SET: begin
				scl_q = 1'b0; drv_q = 1'b1; sda_q = ~ack_sel;
			end
			default: ;
		endcase
		wait_left = phase_len(us);
	endtask

	task automatic seq_end();
		ph = i2cm_pkg::PH_IDLE;
		wait_left = 0;
		fin = 1'b1;
	endtask

	task automatic step_bus(input i2cm_pkg::req_t r, output i2cm_pkg::rsp_t o);
		fin = 1'b0;
		if (ph == i2cm_pkg::PH_IDLE) begin
			if (r.cmd_valid && r.func <= i2cm_pkg::FN_READ) begin
				bit_cnt = 4'd0;
				case (r.func)
					i2cm_pkg::FN_START: enter_phase(i2cm_pkg::PH_ST_HI);
					i2cm_pkg::FN_STOP: enter_phase(i2cm_pkg::PH_SP_SDA);
					i2cm_pkg::FN_SEND: begin
						shreg = r.tx_byte;
						enter_phase(i2cm_pkg::PH_TX_SET);
					end
					i2cm_pkg::FN_ACK: enter_phase(i2cm_pkg::PH_AK_REL);
					default: begin
						ack_sel = r.send_ack;
						shreg = 8'd0;
						enter_phase(i2cm_pkg::PH_RX_LOW);
					end
				endcase
			end
		end else begin
			if (wait_left > 0) wait_left--;
			if (wait_left == 0) begin
				case (ph)
					i2cm_pkg::PH_ST_HI: enter_phase(i2cm_pkg::PH_ST_LO);
					i2cm_pkg::PH_ST_LO: begin
						scl_q = 1'b0;
						seq_end();
					end
					i2cm_pkg::PH_SP_SDA: enter_phase(i2cm_pkg::PH_SP_CLK);
					i2cm_pkg::PH_SP_CLK: enter_phase(i2cm_pkg::PH_SP_REL);
					i2cm_pkg::PH_TX_SET: enter_phase(i2cm_pkg::PH_TX_HIGH);
					i2cm_pkg::PH_TX_HIGH: enter_phase(i2cm_pkg::PH_TX_LOW);
					i2cm_pkg::PH_TX_LOW: begin
						bit_cnt = bit_cnt + 4'd1;
						if (bit_cnt < i2cm_pkg::BYTE_BITS) begin
							shreg = {shreg[6:0], 1'b0};
							enter_phase(i2cm_pkg::PH_TX_SET);
						end else begin
							seq_end();
						end
					end
					i2cm_pkg::PH_AK_REL: enter_phase(i2cm_pkg::PH_AK_HIGH);
					i2cm_pkg::PH_AK_HIGH: begin
						ack_q = r.sda_in;
						scl_q = 1'b0;
						seq_end();
					end
					i2cm_pkg::PH_RX_LOW: enter_phase(i2cm_pkg::PH_RX_HIGH);
					i2cm_pkg::PH_RX_HIGH: begin
						shreg = {shreg[6:0], r.sda_in};
						bit_cnt = bit_cnt + 4'd1;
						if (bit_cnt < i2cm_pkg::BYTE_BITS) begin
							enter_phase(i2cm_pkg::PH_RX_LOW);
						end else begin
							enter_phase(i2cm_pkg::PH_RA_SET);
						end
					end
					i2cm_pkg::PH_RA_SET: enter_phase(i2cm_pkg::PH_RA_HIGH);
					i2cm_pkg::PH_RA_HIGH: begin
						scl_q = 1'b0;
						if (ack_sel) begin
							rx_q = shreg;
							seq_end();
						end else begin
							enter_phase(i2cm_pkg::PH_RA_TAIL);
						end
					end
					i2cm_pkg::PH_RA_TAIL: begin
						rx_q = shreg;
						seq_end();
					end
					default: seq_end();
				endcase
			end
		end
		o.scl_level = scl_q;
		o.sda_level = sda_q;
		o.sda_drive = drv_q;
		o.busy_res = (ph != i2cm_pkg::PH_IDLE);
		o.done_res = fin;
		o.rx_byte = rx_q;
		o.ack_seen = ack_q;
	endtask

	task automatic report_mismatch(input string what);
		err_cnt++;
		$display("[%0t] mismatch at result %0d: %s", $time, checked_cnt, what);
	endtask

	task automatic cmp_field(input string name, input logic [7:0] got, input logic [7:0] want);
		if (got !== want) report_mismatch($sformatf("%s got %0h expected %0h", name, got, want));
	endtask

	// request driver
	always @(posedge clk) begin : drive_req
		i2cm_pkg::rsp_t nxt;
		static int gap_left = 0;
		static bit draining = 1'b0;
		static bit pause_done = 1'b0;
		if (!arst_n) begin
			req_valid <= 1'b0;
		end else begin
			if (req_valid && !req_stall) begin
				step_bus(req, nxt);
				pin_state_q.push_back(nxt);
				taken_cnt <= taken_cnt + 1;
			end
			if (!req_valid || !req_stall) begin
				if (!pause_done && taken_cnt >= 400) begin
					pause_done = 1'b1;
					draining = 1'b1;
					req_valid <= 1'b0;
				end else if (draining) begin
					if (checked_cnt == taken_cnt) draining = 1'b0;
					req_valid <= 1'b0;
				end else if (gap_left > 0) begin
					gap_left--;
					req_valid <= 1'b0;
				end else if (tick_q.size() > 0) begin
					req <= tick_q.pop_front();
					req_valid <= 1'b1;
					if (!calm && $urandom_range(0, 9) == 0) gap_left = $urandom_range(1, 5);
				end else begin
					req_valid <= 1'b0;
				end
			end
		end
	end

	// result stall, with one long hold
	always @(posedge clk) begin : drive_stall
		static int stall_left = 0;
		static bit hold_done = 1'b0;
		if (arst_n) begin
			if (!hold_done && taken_cnt >= 150) begin
				hold_done = 1'b1;
				stall_left = 300;
			end else if (stall_left == 0 && !calm && $urandom_range(0, 7) == 0) begin
				stall_left = $urandom_range(1, 5);
			end
			if (stall_left > 0) begin
				stall_left--;
				rsp_stall <= 1'b1;
			end else begin
				rsp_stall <= 1'b0;
			end
		end
	end

	// result monitor
	always @(posedge clk) begin : watch_rsp
		i2cm_pkg::rsp_t want;
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (pin_state_q.size() == 0) begin
				report_mismatch("result with nothing expected");
			end else begin
				want = pin_state_q.pop_front();
				cmp_field("scl_level", 8'(rsp.scl_level), 8'(want.scl_level));
				cmp_field("sda_level", 8'(rsp.sda_level), 8'(want.sda_level));
				cmp_field("sda_drive", 8'(rsp.sda_drive), 8'(want.sda_drive));
				cmp_field("busy_res", 8'(rsp.busy_res), 8'(want.busy_res));
				cmp_field("done_res", 8'(rsp.done_res), 8'(want.done_res));
				cmp_field("rx_byte", rsp.rx_byte, want.rx_byte);
				cmp_field("ack_seen", 8'(rsp.ack_seen), 8'(want.ack_seen));
				checked_cnt <= checked_cnt + 1;
			end
		end
	end

	// watchdog on handshake activity
	always @(posedge clk) begin : watchdog
		static int idle_cyc = 0;
		if (arst_n) begin
			if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cyc = 0;
			else idle_cyc++;
			if (idle_cyc >= 2000) begin
				$display("timeout: no handshake for %0d cycles", idle_cyc);
				$display("i2c_master_bit_engine test failed");
				$finish;
			end
		end
	end

	function automatic logic sda_for(input int mode);
		return (mode > 1) ? 1'($urandom_range(0, 1)) : mode[0];
	endfunction

	task automatic push_tick(input logic v, input logic [2:0] f, input logic [7:0] b,
			input logic a, input logic s);
		i2cm_pkg::req_t r;
		r.cmd_valid = v;
		r.func = f;
		r.tx_byte = b;
		r.send_ack = a;
		r.sda_in = s;
		tick_q.push_back(r);
		pushed_cnt++;
	endtask

	// one command and exactly the ticks it runs for; busy ticks carry ignored commands
	task automatic run_cmd(input logic [2:0] f, input logic [7:0] b, input logic a,
			input int sda_mode);
		int unsigned t, n;
		t = (tick_rate == 8'd0) ? 1 : tick_rate;
		case (f)
			i2cm_pkg::FN_START: n = 8 * t;
			i2cm_pkg::FN_STOP: n = 8 * t + 1;
			i2cm_pkg::FN_SEND: n = 48 * t;
			i2cm_pkg::FN_ACK: n = 4 * t;
			default: n = a ? 36 * t : 38 * t;
		endcase
		push_tick(1'b1, f, b, a, sda_for(sda_mode));
		repeat (n) push_tick(1'($urandom_range(0, 1)), 3'($urandom_range(0, 7)),
			8'($urandom), 1'($urandom), sda_for(sda_mode));
		work_items += n + 1;
	endtask

	task automatic random_phase(input int budget);
		int goal;
		goal = work_items + budget;
		while (work_items < goal) begin
			if ($urandom_range(0, 9) != 0)
				run_cmd(3'($urandom_range(0, 4)), 8'($urandom), 1'($urandom), 2);
			repeat ($urandom_range(0, 3))
				push_tick(1'($urandom_range(0, 1)), 3'($urandom_range(5, 7)), 8'($urandom),
					1'($urandom), 1'($urandom));
		end
	endtask

	// drain, let the engine settle, then change the tick rate
	task automatic retune(input logic [7:0] v);
		wait (taken_cnt == pushed_cnt && checked_cnt == pushed_cnt);
		repeat (4) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_data <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		tick_rate = v;
		@(negedge clk);
	endtask

	initial begin
		// reset rate
		run_cmd(i2cm_pkg::FN_ACK, 8'h00, 1'b0, 1);
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// zero rate acts as one tick per us
		retune(8'd0);
		run_cmd(i2cm_pkg::FN_START, 8'h00, 1'b0, 2);
		push_tick(1'b1, 3'd5, 8'h00, 1'b0, 1'b0);
		push_tick(1'b1, 3'd6, 8'hFF, 1'b1, 1'b1);
		push_tick(1'b1, 3'd7, 8'h5A, 1'b0, 1'b1);
		run_cmd(i2cm_pkg::FN_SEND, 8'h00, 1'b0, 2);
		run_cmd(i2cm_pkg::FN_SEND, 8'hFF, 1'b1, 2);
		run_cmd(i2cm_pkg::FN_SEND, 8'hA5, 1'b0, 2);
		run_cmd(i2cm_pkg::FN_ACK, 8'h00, 1'b0, 0);
		run_cmd(i2cm_pkg::FN_ACK, 8'h00, 1'b0, 1);
		run_cmd(i2cm_pkg::FN_READ, 8'h00, 1'b1, 1);
		run_cmd(i2cm_pkg::FN_READ, 8'hFF, 1'b0, 0);
		run_cmd(i2cm_pkg::FN_READ, 8'h3C, 1'b1, 2);
		run_cmd(i2cm_pkg::FN_STOP, 8'h00, 1'b0, 2);

		retune(8'd1);
		random_phase(80);
		retune(8'd2);
		random_phase(50);

		calm = 1'b1;
		retune(8'd1);
		random_phase(50);

		wait (taken_cnt == pushed_cnt && checked_cnt == pushed_cnt);
		repeat (10) @(posedge clk);
		if (pin_state_q.size() != 0) report_mismatch("results never delivered");
		if (err_cnt == 0) begin
			$display("i2c_master_bit_engine test passed");
		end else begin
			$display("i2c_master_bit_engine test failed");
		end
		$finish;
	end

endmodule

### i2c_master_bit_engine.f
src/i2cm_pkg.sv
src/i2cm_core.sv
src/i2c_master_bit_engine.sv
tb/sv/tb_i2c_master_bit_engine.sv
